@@ sv/tsbe_pkg.sv @@
// Package for the threshold state block with backdated edges.
// Holds field widths, register indexes, the cell command and the control state type.
// No dependencies.
package tsbe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEAD_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEAD  = 2'd2;

    typedef struct packed {
        logic update;
        logic rewrite;
        logic shift;
        logic append_val;
        logic fill_val;
    } tsbe_cell_cmd_t;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } tsbe_state_t;

endpackage

@@ sv/tsbe_if.sv @@
// Item channel interfaces for the threshold state block: samples in, flags out.
// Depends on tsbe_pkg for field widths.
interface tsbe_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsbe_pkg::SAMPLE_W-1:0] sample;
    logic                                end_of_run;

    modport source (output valid, output sample, output end_of_run, input ready);
    modport sink   (input valid, input sample, input end_of_run, output ready);
endinterface

interface tsbe_out_if;
    logic valid;
    logic ready;
    logic active;
    logic final_res;

    modport source (output valid, output active, output final_res, input ready);
    modport sink   (input valid, input active, input final_res, output ready);
endinterface

@@ sv/tsbe_cell.sv @@
// One cell of the flag window: holds one flag, applies append and rewrite, shifts left.
// Depends on tsbe_pkg for the cell command struct.
module tsbe_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  tsbe_pkg::tsbe_cell_cmd_t cmd,
    input  logic [CW-1:0]           held,
    input  logic [CW-1:0]           lo,
    input  logic                    right_in,
    output logic                    upd
);

    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic flag_reg;
    logic flag_next;

    always_comb
    begin
        upd = flag_reg;
        if (cmd.update)
        begin
            if (held == IDX_V)
            begin
                upd = cmd.append_val;
            end
            if (cmd.rewrite && (lo <= IDX_V) && (IDX_V <= held))
            begin
                upd = cmd.fill_val;
            end
        end
        flag_next = cmd.shift ? right_in : upd;
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

endmodule

@@ sv/threshold_state_with_backdated_edges_top.sv @@
// Top level of the threshold state block with backdated edges.
// Depends on tsbe_pkg, tsbe_in_if, tsbe_out_if and tsbe_cell.
//
// Each sample is taken while the output register is free: it is compared with
// the threshold, the previous state is appended as a flag to a row of DEPTH
// cells, and on a crossing the newest lead+1 flags are rewritten at once. A
// sample that fills the window loads the oldest flag into the output register
// at the same edge, so it shows on the flags port in the next cycle. A sample
// marked end_of_run starts a drain of all held flags (1 to DEPTH), one per
// cycle out of the oldest cell while the flags port is not stalled, and no
// sample is taken until the drain ends. An output register sits between the
// window and the flags port.
module threshold_state_with_backdated_edges_top #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tsbe_in_if.sink                            samples,
    tsbe_out_if.source                         flags,
    input  logic                               wr_en,
    input  logic [tsbe_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [tsbe_pkg::CFG_DATA_W-1:0]    wr_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > tsbe_pkg::LEAD_W + 1) ? CW : tsbe_pkg::LEAD_W + 1) + 1;
    localparam logic [CW-1:0] FULL_V = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_V  = CW'(1);

    logic signed [tsbe_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [tsbe_pkg::LEAD_W-1:0]          on_lead_reg;
    logic [tsbe_pkg::LEAD_W-1:0]          off_lead_reg;

    tsbe_pkg::tsbe_state_t state_reg;
    tsbe_pkg::tsbe_state_t state_next;
    logic [CW-1:0]         held_reg;
    logic [CW-1:0]         held_next;
    logic                  cur_state_reg;
    logic                  cur_state_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic out_active_reg;
    logic out_active_next;
    logic out_final_reg;
    logic out_final_next;

    logic                     space;
    logic                     in_ready;
    logic                     drain_step;
    logic                     accept;
    logic                     above;
    logic                     st;
    logic [CW-1:0]            held_new;
    logic [tsbe_pkg::LEAD_W-1:0] lead;
    logic [SW-1:0]            span;
    logic [CW-1:0]            lo;
    logic                     emit_full;
    tsbe_pkg::tsbe_cell_cmd_t cmd;
    logic [DEPTH-1:0]         upd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            on_lead_reg   <= '0;
            off_lead_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tsbe_pkg::CFG_THRESHOLD: threshold_reg <= $signed(wr_data);
                tsbe_pkg::CFG_ON_LEAD:   on_lead_reg   <= wr_data[tsbe_pkg::LEAD_W-1:0];
                tsbe_pkg::CFG_OFF_LEAD:  off_lead_reg  <= wr_data[tsbe_pkg::LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign space = !out_valid_reg || flags.ready;

    // control outputs
    always_comb
    begin
        in_ready   = 1'b0;
        drain_step = 1'b0;
        unique case (state_reg)
            tsbe_pkg::ST_RUN:   in_ready   = space;
            tsbe_pkg::ST_DRAIN: drain_step = space;
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsbe_pkg::ST_RUN:
            begin
                if (accept && samples.end_of_run)
                begin
                    state_next = tsbe_pkg::ST_DRAIN;
                end
            end
            tsbe_pkg::ST_DRAIN:
            begin
                if (drain_step && (held_reg == ONE_V))
                begin
                    state_next = tsbe_pkg::ST_RUN;
                end
            end
            default: state_next = tsbe_pkg::ST_RUN;
        endcase
    end

    assign samples.ready = in_ready;
    assign accept        = samples.valid && in_ready;

    // datapath control
    always_comb
    begin
        above    = samples.sample >= threshold_reg;
        st       = (held_reg == '0) ? above : cur_state_reg;
        held_new = held_reg + ONE_V;
        lead     = above ? on_lead_reg : off_lead_reg;
        span     = SW'(held_new) - SW'(lead) - SW'(1);
        lo       = span[SW-1] ? '0 : span[CW-1:0];
        emit_full = accept && !samples.end_of_run && (held_new == FULL_V);

        cmd.update     = accept;
        cmd.rewrite    = above != st;
        cmd.shift      = emit_full || drain_step;
        cmd.append_val = st;
        cmd.fill_val   = above;

        held_next      = held_reg;
        cur_state_next = cur_state_reg;
        if (accept)
        begin
            cur_state_next = above;
            held_next      = emit_full ? FULL_V - ONE_V : held_new;
        end
        else if (drain_step)
        begin
            held_next = held_reg - ONE_V;
        end

        out_valid_next  = out_valid_reg && !flags.ready;
        out_active_next = out_active_reg;
        out_final_next  = out_final_reg;
        if (emit_full || drain_step)
        begin
            out_valid_next  = 1'b1;
            out_active_next = upd[0];
            out_final_next  = drain_step && (held_reg == ONE_V);
        end
    end

    // flag window
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic right;
        if (i == DEPTH - 1)
        begin : g_end
            assign right = 1'b0;
        end
        else
        begin : g_mid
            assign right = upd[i+1];
        end

        tsbe_cell #(
            .DEPTH (DEPTH),
            .IDX   (i),
            .CW    (CW)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .held     (held_reg),
            .lo       (lo),
            .right_in (right),
            .upd      (upd[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsbe_pkg::ST_RUN;
            held_reg      <= '0;
            cur_state_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cur_state_reg <= cur_state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_active_reg <= out_active_next;
        out_final_reg  <= out_final_next;
    end

    assign flags.valid     = out_valid_reg;
    assign flags.active    = out_active_reg;
    assign flags.final_res = out_final_reg;

    a_run_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsbe_pkg::ST_RUN) |-> (held_reg < FULL_V))
        else $error("window full while taking samples");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsbe_pkg::ST_DRAIN) |-> (held_reg != '0))
        else $error("drain with empty window");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_step && (held_reg == ONE_V)) |=>
        ((state_reg == tsbe_pkg::ST_RUN) && (held_reg == '0) && out_valid_reg && out_final_reg))
        else $error("drain did not end with the final item");

endmodule

@@ bench/threshold_state_with_backdated_edges_top_test.sv @@
// Self-checking testbench for the threshold state block with backdated edges.
// A directed table and random sample runs are checked against a bench predictor or table flags.
// Depends on tsbe_pkg, tsbe_in_if, tsbe_out_if and threshold_state_with_backdated_edges_top.
module threshold_state_with_backdated_edges_top_test;

    localparam int WINDOW_DEPTH  = 16;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = WINDOW_DEPTH + 4;

    localparam logic [tsbe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [tsbe_pkg::CFG_IDX_W-1:0]   idx;
        logic [15:0]                      value;
        logic [4:0]                       reps;
        logic                             eor;
        logic                             typed;
        logic                             exp_active;
    } directed_row_t;

    typedef struct packed {
        logic active;
        logic final_res;
    } flag_item_t;

    localparam int N_ROWS = 22;

    directed_row_t directed_rows [N_ROWS] = '{
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h7FFF, 5'd1,  1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h8000, 5'd1,  1'b1, 1'b1, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h0000, 5'd1,  1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'hFFFF, 5'd1,  1'b1, 1'b1, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_THRESHOLD, 16'h0100, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_ON_LEAD,   16'h000F, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_OFF_LEAD,  16'h000F, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h8000, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h0100, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h00FF, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h0100, 5'd12, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h8000, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h7FFF, 5'd1,  1'b1, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_THRESHOLD, 16'h7FFF, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_ON_LEAD,   16'h0000, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_OFF_LEAD,  16'h0007, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_CONFIG, CFG_SPARE,               16'hFFFF, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h7FFE, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h7FFF, 5'd1,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h7FFE, 5'd1,  1'b1, 1'b0, 1'b0},
        '{ROW_CONFIG, tsbe_pkg::CFG_THRESHOLD, 16'h8000, 5'd0,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, tsbe_pkg::CFG_THRESHOLD, 16'h8000, 5'd1,  1'b1, 1'b1, 1'b1}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [tsbe_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [tsbe_pkg::CFG_DATA_W-1:0] wr_data;

    tsbe_in_if  sample_ch ();
    tsbe_out_if flag_ch ();

    threshold_state_with_backdated_edges_top #(
        .DEPTH (WINDOW_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .flags    (flag_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    logic signed [15:0] thr_level;
    logic [3:0]         rise_lead;
    logic [3:0]         fall_lead;
    logic               pending_flags [WINDOW_DEPTH];
    int                 pending_count;
    logic               state_on;

    flag_item_t expected_flags [$];
    flag_item_t want;

    bit src_steady;
    bit sink_steady;
    int sink_wait;
    int sink_draw;

    int samples_sent;
    int flags_checked;
    int reg_writes;
    int mismatch_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic void predict_flags(input logic signed [15:0] s, input logic eor,
                                          input bit record);
        logic above;
        int   span;
        above = (s >= thr_level);
        if (pending_count == 0)
            state_on = above;
        pending_flags[pending_count] = state_on;
        pending_count++;
        if (above != state_on)
        begin
            span = above ? int'(rise_lead) + 1 : int'(fall_lead) + 1;
            if (span > pending_count)
                span = pending_count;
            for (int i = 0; i < span; i++)
                pending_flags[pending_count - 1 - i] = above;
            state_on = above;
        end
        if (eor)
        begin
            if (record)
                for (int i = 0; i < pending_count; i++)
                    expected_flags.insert(expected_flags.size(),
                                          flag_item_t'{pending_flags[i],
                                                       i == pending_count - 1});
            pending_count = 0;
        end
        else if (pending_count == WINDOW_DEPTH)
        begin
            if (record)
                expected_flags.insert(expected_flags.size(),
                                      flag_item_t'{pending_flags[0], 1'b0});
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                pending_flags[i] = pending_flags[i + 1];
            pending_count = WINDOW_DEPTH - 1;
        end
    endfunction

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = 32767;
            1: v = -32768;
            2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            default: v = int'(thr_level) + int'($urandom_range(0, 1023)) - 512;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [3:0] pick_lead();
        case ($urandom_range(0, 3))
            0: return 4'd0;
            1: return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic write_reg(input logic [tsbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            tsbe_pkg::CFG_THRESHOLD: thr_level = data;
            tsbe_pkg::CFG_ON_LEAD:   rise_lead = data[3:0];
            tsbe_pkg::CFG_OFF_LEAD:  fall_lead = data[3:0];
            default: ;
        endcase
        reg_writes++;
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(input logic [15:0] s, input logic eor, input bit record);
        int gap;
        gap = draw_gap(src_steady);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.sample     <= s;
        sample_ch.end_of_run <= eor;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predict_flags(s, eor, record);
        samples_sent++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_ch.ready <= 1'b0;
            sink_wait     <= 0;
        end
        else if (flag_ch.valid && flag_ch.ready)
        begin
            sink_draw = draw_gap(sink_steady);
            flag_ch.ready <= (sink_draw == 0);
            sink_wait     <= sink_draw;
        end
        else if (!flag_ch.ready)
        begin
            if (sink_wait <= 1)
                flag_ch.ready <= 1'b1;
            sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && flag_ch.valid && flag_ch.ready)
        begin
            if (expected_flags.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected flag item, expected none, got %0b/%0b",
                         $time, flag_ch.active, flag_ch.final_res);
            end
            else
            begin
                want = expected_flags.pop_front();
                if (flag_ch.active !== want.active)
                begin
                    mismatch_count++;
                    $display("%0t: flag %0d active expected %0b got %0b",
                             $time, flags_checked, want.active, flag_ch.active);
                end
                if (flag_ch.final_res !== want.final_res)
                begin
                    mismatch_count++;
                    $display("%0t: flag %0d final_res expected %0b got %0b",
                             $time, flags_checked, want.final_res, flag_ch.final_res);
                end
                flags_checked++;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles with %0d flag items outstanding",
                 CYCLE_LIMIT, expected_flags.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int   k;
        int   random_sent;
        int   phase_len;
        int   phase_sent;
        int   run_len;
        logic last;

        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = tsbe_pkg::CFG_THRESHOLD;
        wr_data              = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample     = '0;
        sample_ch.end_of_run = 1'b0;
        thr_level            = '0;
        rise_lead            = '0;
        fall_lead            = '0;
        pending_count        = 0;
        state_on             = 1'b0;
        src_steady           = 1'b0;
        sink_steady          = 1'b0;
        samples_sent         = 0;
        flags_checked        = 0;
        reg_writes           = 0;
        mismatch_count       = 0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            pending_flags[i] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                wait_drained();
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end
            else
            begin
                for (k = 0; k < int'(directed_rows[r].reps); k++)
                begin
                    last = directed_rows[r].eor && (k == int'(directed_rows[r].reps) - 1);
                    push_sample(directed_rows[r].value, last, !directed_rows[r].typed);
                    if (directed_rows[r].typed)
                        expected_flags.insert(expected_flags.size(),
                                              flag_item_t'{directed_rows[r].exp_active,
                                                           1'b1});
                end
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: write_reg(tsbe_pkg::CFG_THRESHOLD, 16'h8000);
                1: write_reg(tsbe_pkg::CFG_THRESHOLD, 16'h7FFF);
                default: write_reg(tsbe_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
            endcase
            write_reg(tsbe_pkg::CFG_ON_LEAD, {12'($urandom_range(0, 4095)), pick_lead()});
            write_reg(tsbe_pkg::CFG_OFF_LEAD, {12'($urandom_range(0, 4095)), pick_lead()});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(30, 70);
            phase_sent  = 0;
            while (phase_sent < phase_len)
            begin
                case ($urandom_range(0, 7))
                    0: run_len = 1;
                    1: run_len = $urandom_range(14, 18);
                    2: run_len = $urandom_range(30, 60);
                    default: run_len = $urandom_range(2, 12);
                endcase
                for (k = 0; k < run_len; k++)
                    push_sample(pick_sample(), k == run_len - 1, 1'b1);
                phase_sent  += run_len;
                random_sent += run_len;
            end
        end

        wait_drained();

        $display("Sent %0d samples over %0d register writes and checked %0d flag items.",
                 samples_sent, reg_writes, flags_checked);
        $display("Runs covered threshold and lead extremes, full-window shifts and drains.");
        if (mismatch_count == 0 && expected_flags.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
